@@ sv/pes_pkg.sv @@
package pes_pkg;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_NEXT   = 2'd1,
        KIND_CHARGE = 2'd2,
        KIND_REFILL = 2'd3
    } t_kind;

    localparam logic [2:0] Q_LOW  = 3'd0;
    localparam logic [2:0] Q_MID  = 3'd1;
    localparam logic [2:0] Q_HIGH = 3'd2;
    localparam logic [2:0] Q_CRIT = 3'd3;
    localparam logic [2:0] Q_SYS  = 3'd4;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_FULL      = 3'd1;
    localparam logic [2:0] STS_EMPTY     = 3'd2;
    localparam logic [2:0] STS_NO_CREDIT = 3'd3;
    localparam logic [2:0] STS_WAIT_GAP  = 3'd4;

    localparam logic [1:0] CFG_SLICE_HIGH = 2'd0;
    localparam logic [1:0] CFG_SLICE_MID  = 2'd1;
    localparam logic [1:0] CFG_SLICE_LOW  = 2'd2;

    localparam logic [15:0] SLICE_HIGH_RST = 16'd50;
    localparam logic [15:0] SLICE_MID_RST  = 16'd30;
    localparam logic [15:0] SLICE_LOW_RST  = 16'd20;
    localparam logic [31:0] NO_GAP         = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SYS, S_CRIT, S_SHIFT, S_USER, S_USER_RD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_LATCH, OP_EXEC, OP_SYS, OP_CRIT, OP_SHIFT, OP_USER, OP_USER_RD
    } t_op;

    typedef struct packed {
        t_op op;
    } t_pes_cmd;

    typedef struct packed {
        logic is_next;
        logic sys_busy;
        logic crit_busy;
        logic due_hit;
        logic scan_more;
        logic shift_more;
        logic user_found;
    } t_pes_stat;

endpackage

@@ sv/pes_req_if.sv @@
interface pes_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  priority_req;
    logic [31:0] event_id;
    logic [15:0] event_state;
    logic [31:0] trigger_time;
    logic [31:0] now;
    logic [14:0] elapsed;

    modport source (output valid, kind, priority_req, event_id, event_state, trigger_time,
                    now, elapsed, input ready);
    modport sink (input valid, kind, priority_req, event_id, event_state, trigger_time,
                  now, elapsed, output ready);
endinterface

@@ sv/pes_rsp_if.sv @@
interface pes_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_id;
    logic [15:0] out_state;
    logic [2:0]  out_priority;
    logic [31:0] wait_gap;

    modport source (output valid, status, out_id, out_state, out_priority, wait_gap,
                    input ready);
    modport sink (input valid, status, out_id, out_state, out_priority, wait_gap,
                  output ready);
endinterface

@@ sv/pes_ctrl.sv @@
module pes_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  pes_pkg::t_pes_stat  i_stat,
    output pes_pkg::t_pes_cmd   o_cmd
);

    pes_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pes_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = pes_pkg::OP_NONE;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            pes_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = pes_pkg::OP_LATCH;
                    n_state  = pes_pkg::S_EXEC;
                end
            end
            pes_pkg::S_EXEC: begin
                o_cmd.op = pes_pkg::OP_EXEC;
                if (!i_stat.is_next) n_state = pes_pkg::S_OUT;
                else if (i_stat.sys_busy) n_state = pes_pkg::S_SYS;
                else if (i_stat.crit_busy) n_state = pes_pkg::S_CRIT;
                else n_state = pes_pkg::S_USER;
            end
            pes_pkg::S_SYS: begin
                o_cmd.op = pes_pkg::OP_SYS;
                n_state  = pes_pkg::S_OUT;
            end
            pes_pkg::S_CRIT: begin
                o_cmd.op = pes_pkg::OP_CRIT;
                if (i_stat.due_hit) begin
                    n_state = i_stat.scan_more ? pes_pkg::S_SHIFT : pes_pkg::S_OUT;
                end else begin
                    n_state = i_stat.scan_more ? pes_pkg::S_CRIT : pes_pkg::S_USER;
                end
            end
            pes_pkg::S_SHIFT: begin
                o_cmd.op = pes_pkg::OP_SHIFT;
                n_state  = i_stat.shift_more ? pes_pkg::S_SHIFT : pes_pkg::S_OUT;
            end
            pes_pkg::S_USER: begin
                o_cmd.op = pes_pkg::OP_USER;
                n_state  = i_stat.user_found ? pes_pkg::S_USER_RD : pes_pkg::S_OUT;
            end
            pes_pkg::S_USER_RD: begin
                o_cmd.op = pes_pkg::OP_USER_RD;
                n_state  = pes_pkg::S_OUT;
            end
            pes_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = pes_pkg::S_IDLE;
            end
            default: n_state = pes_pkg::S_IDLE;
        endcase
    end

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("request and response open together");
    a_shift_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pes_pkg::S_SHIFT) |-> ($past(r_state) == pes_pkg::S_SHIFT ||
        $past(r_state) == pes_pkg::S_CRIT)) else $error("compaction without a hit");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid) else $error("response dropped");

endmodule

@@ sv/pes_dp.sv @@
module pes_dp #(
    parameter int USER_DEPTH = 16,
    parameter int CRIT_DEPTH = 16,
    parameter int SYS_DEPTH  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_kind,
    input  logic [2:0]         i_priority_req,
    input  logic [31:0]        i_event_id,
    input  logic [15:0]        i_event_state,
    input  logic [31:0]        i_trigger_time,
    input  logic [31:0]        i_now,
    input  logic [14:0]        i_elapsed,
    input  pes_pkg::t_pes_cmd  i_cmd,
    output pes_pkg::t_pes_stat o_stat,
    output logic [2:0]         o_status,
    output logic [31:0]        o_out_id,
    output logic [15:0]        o_out_state,
    output logic [2:0]         o_out_priority,
    output logic [31:0]        o_wait_gap
);

    localparam int UW  = $clog2(USER_DEPTH);
    localparam int CW  = $clog2(CRIT_DEPTH);
    localparam int SW  = $clog2(SYS_DEPTH);
    localparam int UAW = $clog2(3 * USER_DEPTH);

    logic [47:0] r_sys_mem  [SYS_DEPTH];
    logic [79:0] r_crit_mem [CRIT_DEPTH];
    logic [47:0] r_user_mem [3 * USER_DEPTH];
    logic [47:0] r_sys_rd, r_user_rd;
    logic [79:0] r_crit_rd;

    logic [UW-1:0] r_uhead [3];
    logic [UW-1:0] r_utail [3];
    logic [CW-1:0] r_chead, r_ctail;
    logic [SW-1:0] r_shead, r_stail;
    logic signed [31:0] r_credit [3];
    logic [15:0] r_slice [3];

    pes_pkg::t_kind r_kind;
    logic [2:0]  r_prio;
    logic [47:0] r_rec;
    logic [31:0] r_trig, r_now, r_gap;
    logic [14:0] r_elapsed;
    logic [CW-1:0] r_k;
    logic [1:0]  r_q;
    logic [47:0] r_hit_rec;

    logic [2:0]  r_status;
    logic [47:0] r_orec;
    logic [2:0]  r_oprio;
    logic [31:0] r_ogap;

    function automatic logic [CW-1:0] crit_at(input logic [CW-1:0] h, input logic [CW+1:0] off);
        logic [CW+1:0] s;
        s = {2'b00, h} + off;
        if (s >= (CW+2)'(CRIT_DEPTH)) s = s - (CW+2)'(CRIT_DEPTH);
        return s[CW-1:0];
    endfunction

    logic [CW-1:0] crit_cnt;
    logic [CW+1:0] k1, k2;
    logic sys_busy, crit_busy, due_hit;
    logic [31:0] due, diff;
    logic user_found, user_busy;
    logic [1:0] sel_q;
    logic push_full;
    logic [UW-1:0] q_head [3];

    always_comb begin
        crit_cnt  = (r_ctail >= r_chead) ? (r_ctail - r_chead)
                  : CW'((CW+1)'(r_ctail) + (CW+1)'(CRIT_DEPTH) - (CW+1)'(r_chead));
        k1        = (CW+2)'(r_k) + (CW+2)'(1);
        k2        = (CW+2)'(r_k) + (CW+2)'(2);
        sys_busy  = r_shead != r_stail;
        crit_busy = r_chead != r_ctail;
        due       = r_crit_rd[79:48];
        due_hit   = due <= r_now;
        diff      = due - r_now;
        user_found = 1'b0;
        user_busy  = 1'b0;
        sel_q      = 2'd0;
        for (int q = 2; q >= 0; q--) begin
            q_head[q] = r_uhead[q];
            if (r_uhead[q] != r_utail[q]) begin
                user_busy = 1'b1;
                if (r_credit[q] > 0 && !user_found) begin
                    user_found = 1'b1;
                    sel_q      = 2'(q);
                end
            end
        end
        case (r_prio)
            pes_pkg::Q_LOW, pes_pkg::Q_MID, pes_pkg::Q_HIGH:
                push_full = ((r_utail[r_prio[1:0]] == UW'(USER_DEPTH - 1)) ? UW'(0)
                            : r_utail[r_prio[1:0]] + UW'(1)) == r_uhead[r_prio[1:0]];
            pes_pkg::Q_CRIT:
                push_full = ((r_ctail == CW'(CRIT_DEPTH - 1)) ? CW'(0) : r_ctail + CW'(1))
                            == r_chead;
            pes_pkg::Q_SYS:
                push_full = ((r_stail == SW'(SYS_DEPTH - 1)) ? SW'(0) : r_stail + SW'(1))
                            == r_shead;
            default: push_full = 1'b1;
        endcase
        o_stat.is_next    = r_kind == pes_pkg::KIND_NEXT;
        o_stat.sys_busy   = sys_busy;
        o_stat.crit_busy  = crit_busy;
        o_stat.due_hit    = due_hit;
        o_stat.scan_more  = k1 < (CW+2)'(crit_cnt);
        o_stat.shift_more = k2 < (CW+2)'(crit_cnt);
        o_stat.user_found = user_found;
    end

    // Read addresses follow the command so that data is registered for the next step.
    logic [CW-1:0]  crit_rd_addr;
    logic [UAW-1:0] user_rd_addr;
    always_comb begin
        case (i_cmd.op)
            pes_pkg::OP_EXEC:  crit_rd_addr = r_chead;
            pes_pkg::OP_SHIFT: crit_rd_addr = crit_at(r_chead, k2);
            default:           crit_rd_addr = crit_at(r_chead, k1);
        endcase
        user_rd_addr = UAW'(UAW'(sel_q) * UAW'(USER_DEPTH)) + UAW'(q_head[sel_q]);
    end

    always_ff @(posedge i_clk) begin
        r_sys_rd  <= r_sys_mem[r_shead];
        r_crit_rd <= r_crit_mem[crit_rd_addr];
        r_user_rd <= r_user_mem[user_rd_addr];
        if (i_cmd.op == pes_pkg::OP_EXEC && r_kind == pes_pkg::KIND_PUSH && !push_full) begin
            case (r_prio)
                pes_pkg::Q_CRIT: r_crit_mem[r_ctail] <= {r_trig, r_rec};
                pes_pkg::Q_SYS:  r_sys_mem[r_stail] <= r_rec;
                default: r_user_mem[UAW'(UAW'(r_prio[1:0]) * UAW'(USER_DEPTH))
                                    + UAW'(r_utail[r_prio[1:0]])] <= r_rec;
            endcase
        end
        if (i_cmd.op == pes_pkg::OP_SHIFT) begin
            r_crit_mem[crit_at(r_chead, (CW+2)'(r_k))] <= r_crit_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < 3; q++) begin
                r_uhead[q] <= '0;
                r_utail[q] <= '0;
            end
            r_chead    <= '0;
            r_ctail    <= '0;
            r_shead    <= '0;
            r_stail    <= '0;
            r_slice[2] <= pes_pkg::SLICE_HIGH_RST;
            r_slice[1] <= pes_pkg::SLICE_MID_RST;
            r_slice[0] <= pes_pkg::SLICE_LOW_RST;
            r_credit[2] <= signed'({16'd0, pes_pkg::SLICE_HIGH_RST});
            r_credit[1] <= signed'({16'd0, pes_pkg::SLICE_MID_RST});
            r_credit[0] <= signed'({16'd0, pes_pkg::SLICE_LOW_RST});
            r_kind     <= pes_pkg::KIND_PUSH;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pes_pkg::CFG_SLICE_HIGH: r_slice[2] <= i_cfg_data;
                    pes_pkg::CFG_SLICE_MID:  r_slice[1] <= i_cfg_data;
                    pes_pkg::CFG_SLICE_LOW:  r_slice[0] <= i_cfg_data;
                    default: ;
                endcase
            end
            case (i_cmd.op)
                pes_pkg::OP_LATCH: begin
                    r_kind    <= pes_pkg::t_kind'(i_kind);
                    r_prio    <= i_priority_req;
                    r_rec     <= {i_event_id, i_event_state};
                    r_trig    <= i_trigger_time;
                    r_now     <= i_now;
                    r_elapsed <= i_elapsed;
                end
                pes_pkg::OP_EXEC: begin
                    r_status <= pes_pkg::STS_OK;
                    r_orec   <= '0;
                    r_oprio  <= '0;
                    r_ogap   <= '0;
                    r_k      <= '0;
                    r_gap    <= pes_pkg::NO_GAP;
                    case (r_kind)
                        pes_pkg::KIND_PUSH: begin
                            if (push_full) begin
                                r_status <= pes_pkg::STS_FULL;
                            end else begin
                                case (r_prio)
                                    pes_pkg::Q_CRIT: r_ctail <= (r_ctail == CW'(CRIT_DEPTH - 1))
                                                     ? CW'(0) : r_ctail + CW'(1);
                                    pes_pkg::Q_SYS:  r_stail <= (r_stail == SW'(SYS_DEPTH - 1))
                                                     ? SW'(0) : r_stail + SW'(1);
                                    default: r_utail[r_prio[1:0]] <=
                                        (r_utail[r_prio[1:0]] == UW'(USER_DEPTH - 1))
                                        ? UW'(0) : r_utail[r_prio[1:0]] + UW'(1);
                                endcase
                            end
                        end
                        pes_pkg::KIND_CHARGE: begin
                            if (r_prio < pes_pkg::Q_CRIT) begin
                                logic signed [32:0] v;
                                v = 33'(r_credit[r_prio[1:0]]) - signed'({18'd0, r_elapsed});
                                r_credit[r_prio[1:0]] <= (v[32] && !v[31])
                                    ? signed'(32'h8000_0000) : v[31:0];
                            end
                        end
                        pes_pkg::KIND_REFILL: begin
                            for (int q = 0; q < 3; q++) begin
                                r_credit[q] <= signed'({16'd0, r_slice[q]});
                            end
                        end
                        default: begin
                            if (sys_busy) begin
                                r_shead <= (r_shead == SW'(SYS_DEPTH - 1))
                                           ? SW'(0) : r_shead + SW'(1);
                            end
                        end
                    endcase
                end
                pes_pkg::OP_SYS: begin
                    r_orec  <= r_sys_rd;
                    r_oprio <= pes_pkg::Q_SYS;
                end
                pes_pkg::OP_CRIT: begin
                    if (due_hit) begin
                        r_hit_rec <= r_crit_rd[47:0];
                        if (!o_stat.scan_more) begin
                            r_ctail <= (r_ctail == '0) ? CW'(CRIT_DEPTH - 1) : r_ctail - CW'(1);
                            r_orec  <= r_crit_rd[47:0];
                            r_oprio <= pes_pkg::Q_CRIT;
                        end
                    end else begin
                        if (diff < r_gap) r_gap <= diff;
                        r_k <= k1[CW-1:0];
                    end
                end
                pes_pkg::OP_SHIFT: begin
                    r_k <= k1[CW-1:0];
                    if (!o_stat.shift_more) begin
                        r_ctail <= (r_ctail == '0) ? CW'(CRIT_DEPTH - 1) : r_ctail - CW'(1);
                        r_orec  <= r_hit_rec;
                        r_oprio <= pes_pkg::Q_CRIT;
                    end
                end
                pes_pkg::OP_USER: begin
                    r_q <= sel_q;
                    if (user_found) begin
                        r_uhead[sel_q] <= (r_uhead[sel_q] == UW'(USER_DEPTH - 1))
                                          ? UW'(0) : r_uhead[sel_q] + UW'(1);
                    end else if (user_busy) begin
                        r_status <= pes_pkg::STS_NO_CREDIT;
                    end else if (crit_busy) begin
                        r_status <= pes_pkg::STS_WAIT_GAP;
                        r_ogap   <= r_gap;
                    end else begin
                        r_status <= pes_pkg::STS_EMPTY;
                    end
                end
                pes_pkg::OP_USER_RD: begin
                    r_orec  <= r_user_rd;
                    r_oprio <= {1'b0, r_q};
                end
                default: ;
            endcase
        end
    end

    assign o_status       = r_status;
    assign o_out_id       = r_orec[47:16];
    assign o_out_state    = r_orec[15:0];
    assign o_out_priority = r_oprio;
    assign o_wait_gap     = r_ogap;

    a_shift_needs_crit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pes_pkg::OP_SHIFT || i_cmd.op == pes_pkg::OP_CRIT) |-> crit_busy)
        else $error("critical scan on an empty queue");
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == pes_pkg::OP_CRIT) |-> (r_k < crit_cnt))
        else $error("critical scan past the tail");
    a_credit_only_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != pes_pkg::OP_EXEC) |=> $stable(r_credit[0]) && $stable(r_credit[1])
        && $stable(r_credit[2])) else $error("credit changed outside a request");

endmodule

@@ sv/priority_event_scheduler_top.sv @@
// Push, charge and refill are latched, executed and answered. A next request is also served
// from the system queue, else by a scan of the critical queue (with compaction on a hit),
// else from a user queue that has credit, before the response is given.
// One request is in flight at a time; a new one is taken the cycle after the response leaves.
// Reset empties all queues, restores slices 50/30/20 and loads the credits from them.
module priority_event_scheduler_top #(
    parameter int USER_DEPTH = 16,
    parameter int CRIT_DEPTH = 16,
    parameter int SYS_DEPTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pes_req_if.sink     req,
    pes_rsp_if.source   rsp
);

    pes_pkg::t_pes_cmd  cmd;
    pes_pkg::t_pes_stat stat;

    pes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req.valid),
        .o_in_ready  (req.ready),
        .o_out_valid (rsp.valid),
        .i_out_ready (rsp.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pes_dp #(
        .USER_DEPTH (USER_DEPTH),
        .CRIT_DEPTH (CRIT_DEPTH),
        .SYS_DEPTH  (SYS_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (req.kind),
        .i_priority_req (req.priority_req),
        .i_event_id     (req.event_id),
        .i_event_state  (req.event_state),
        .i_trigger_time (req.trigger_time),
        .i_now          (req.now),
        .i_elapsed      (req.elapsed),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_status       (rsp.status),
        .o_out_id       (rsp.out_id),
        .o_out_state    (rsp.out_state),
        .o_out_priority (rsp.out_priority),
        .o_wait_gap     (rsp.wait_gap)
    );

endmodule

@@ test/pes_sched_checker.sv @@
module pes_sched_checker #(
    parameter int USER_DEPTH = 16,
    parameter int CRIT_DEPTH = 16,
    parameter int SYS_DEPTH  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    pes_req_if          req,
    pes_rsp_if          rsp,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] id;
        logic [15:0] state_word;
        logic [2:0]  prio;
        logic [31:0] gap;
    } t_dispatch;

    logic [15:0] slice_hi, slice_md, slice_lo;
    logic [47:0] sys_q[$];
    logic [47:0] crit_q[$];
    logic [31:0] crit_due_q[$];
    logic [47:0] user_q[3][$];
    logic signed [31:0] credit[3];
    t_dispatch expected_q[$];

    assign o_pending = expected_q.size();

    function automatic int cap_of(logic [2:0] q);
        if (q < pes_pkg::Q_CRIT) return USER_DEPTH - 1;
        if (q == pes_pkg::Q_CRIT) return CRIT_DEPTH - 1;
        return SYS_DEPTH - 1;
    endfunction

    function automatic t_dispatch schedule(logic [1:0] kind, logic [2:0] prio,
                                           logic [47:0] rec, logic [31:0] trig,
                                           logic [31:0] now_t, logic [14:0] elapsed);
        t_dispatch r;
        logic [31:0] gap;
        logic [47:0] e;
        logic signed [32:0] v;
        bit user_busy;
        int n;
        r = '0;
        gap = pes_pkg::NO_GAP;
        user_busy = 0;
        case (kind)
            pes_pkg::KIND_PUSH: begin
                if (prio > pes_pkg::Q_SYS) begin
                    r.status = pes_pkg::STS_FULL;
                end else begin
                    n = (prio == pes_pkg::Q_SYS) ? sys_q.size() :
                        (prio == pes_pkg::Q_CRIT) ? crit_q.size() : user_q[prio].size();
                    if (n >= cap_of(prio)) begin
                        r.status = pes_pkg::STS_FULL;
                    end else if (prio == pes_pkg::Q_SYS) begin
                        sys_q.push_back(rec);
                    end else if (prio == pes_pkg::Q_CRIT) begin
                        crit_q.push_back(rec);
                        crit_due_q.push_back(trig);
                    end else begin
                        user_q[prio].push_back(rec);
                    end
                end
            end
            pes_pkg::KIND_CHARGE: begin
                if (prio < pes_pkg::Q_CRIT) begin
                    v = 33'(credit[prio]) - 33'(signed'({1'b0, elapsed}));
                    if (v < -33'sd2147483648) v = -33'sd2147483648;
                    credit[prio] = v[31:0];
                end
            end
            pes_pkg::KIND_REFILL: begin
                credit[pes_pkg::Q_HIGH] = {16'd0, slice_hi};
                credit[pes_pkg::Q_MID]  = {16'd0, slice_md};
                credit[pes_pkg::Q_LOW]  = {16'd0, slice_lo};
            end
            default: begin
                if (sys_q.size() != 0) begin
                    e = sys_q.pop_front();
                    r = '{pes_pkg::STS_OK, e[47:16], e[15:0], pes_pkg::Q_SYS, 32'd0};
                    return r;
                end
                for (int k = 0; k < crit_q.size(); k++) begin
                    if (crit_due_q[k] <= now_t) begin
                        e = crit_q[k];
                        crit_q.delete(k);
                        crit_due_q.delete(k);
                        r = '{pes_pkg::STS_OK, e[47:16], e[15:0], pes_pkg::Q_CRIT, 32'd0};
                        return r;
                    end
                    if (crit_due_q[k] - now_t < gap) gap = crit_due_q[k] - now_t;
                end
                for (int q = 2; q >= 0; q--) begin
                    if (user_q[q].size() != 0) begin
                        if (credit[q] > 0) begin
                            e = user_q[q].pop_front();
                            r = '{pes_pkg::STS_OK, e[47:16], e[15:0], 3'(q), 32'd0};
                            return r;
                        end
                        user_busy = 1;
                    end
                end
                if (user_busy) r.status = pes_pkg::STS_NO_CREDIT;
                else if (crit_q.size() != 0) begin
                    r.status = pes_pkg::STS_WAIT_GAP;
                    r.gap = gap;
                end else r.status = pes_pkg::STS_EMPTY;
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dispatch got, want;
        if (!i_rst_n) begin
            slice_hi <= pes_pkg::SLICE_HIGH_RST;
            slice_md <= pes_pkg::SLICE_MID_RST;
            slice_lo <= pes_pkg::SLICE_LOW_RST;
            credit[pes_pkg::Q_HIGH] = {16'd0, pes_pkg::SLICE_HIGH_RST};
            credit[pes_pkg::Q_MID]  = {16'd0, pes_pkg::SLICE_MID_RST};
            credit[pes_pkg::Q_LOW]  = {16'd0, pes_pkg::SLICE_LOW_RST};
            sys_q.delete();
            crit_q.delete();
            crit_due_q.delete();
            for (int q = 0; q < 3; q++) user_q[q].delete();
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pes_pkg::CFG_SLICE_HIGH: slice_hi <= i_cfg_data;
                    pes_pkg::CFG_SLICE_MID:  slice_md <= i_cfg_data;
                    pes_pkg::CFG_SLICE_LOW:  slice_lo <= i_cfg_data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready) begin
                expected_q.push_back(schedule(req.kind, req.priority_req,
                    {req.event_id, req.event_state}, req.trigger_time, req.now, req.elapsed));
            end
            if (rsp.valid && rsp.ready) begin
                got = '{rsp.status, rsp.out_id, rsp.out_state, rsp.out_priority, rsp.wait_gap};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status || got.id !== want.id
                            || got.state_word !== want.state_word || got.prio !== want.prio
                            || got.gap !== want.gap) begin
                        $display("%0t: mismatch expected st=%0d id=%h sw=%h pr=%0d gap=%h",
                                 $time, want.status, want.id, want.state_word, want.prio,
                                 want.gap);
                        $display("%0t:          actual   st=%0d id=%h sw=%h pr=%0d gap=%h",
                                 $time, got.status, got.id, got.state_word, got.prio, got.gap);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/priority_event_scheduler_top_tb.sv @@
module priority_event_scheduler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    bit          hold_off;

    pes_req_if req ();
    pes_rsp_if rsp ();

    priority_event_scheduler_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .req(req.sink), .rsp(rsp.source)
    );

    pes_sched_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .req(req), .rsp(rsp), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // The receiver stalls at random, and holds off completely during the long stretch.
    initial begin
        int n;
        rsp.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            rsp.ready <= 1'b1;
            @(posedge i_clk);
            while (hold_off) begin
                rsp.ready <= 1'b0;
                @(posedge i_clk);
            end
            n = gap_len();
            if (n > 0) begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic send(logic [1:0] kind, logic [2:0] prio, logic [31:0] id,
                        logic [15:0] sw, logic [31:0] trig, logic [31:0] now_t,
                        logic [14:0] el);
        int n;
        req.valid        <= 1'b1;
        req.kind         <= kind;
        req.priority_req <= prio;
        req.event_id     <= id;
        req.event_state  <= sw;
        req.trigger_time <= trig;
        req.now          <= now_t;
        req.elapsed      <= el;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        n = gap_len();
        if (n > 0) begin
            req.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic random_request(int now_base);
        int r;
        logic [2:0] prio;
        r = $urandom_range(0, 99);
        prio = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        if (r < 45) begin
            send(pes_pkg::KIND_PUSH, prio, $urandom, 16'($urandom),
                 now_base + $urandom_range(0, 200) - 100, $urandom, 15'($urandom));
        end else if (r < 85) begin
            send(pes_pkg::KIND_NEXT, 3'($urandom), $urandom, 16'($urandom), $urandom,
                 ($urandom_range(0, 9) == 0) ? $urandom : now_base + $urandom_range(0, 100),
                 15'($urandom));
        end else if (r < 95) begin
            send(pes_pkg::KIND_CHARGE, prio, $urandom, 16'($urandom), $urandom, $urandom,
                 ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 20)));
        end else begin
            send(pes_pkg::KIND_REFILL, prio, $urandom, 16'($urandom), $urandom, $urandom,
                 15'($urandom));
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int now_base;
        hold_off   = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        req.valid = 1'b0;
        req.kind = '0;
        req.priority_req = '0;
        req.event_id = '0;
        req.event_state = '0;
        req.trigger_time = '0;
        req.now = '0;
        req.elapsed = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: empty queues, extremes, fullness, unknown queues and timing.
        send(pes_pkg::KIND_NEXT, pes_pkg::Q_LOW, '0, '0, '0, '0, '0);
        send(pes_pkg::KIND_PUSH, 3'd7, '1, '1, '1, '1, '1);
        send(pes_pkg::KIND_CHARGE, 3'd6, '1, '1, '1, '1, '1);
        send(pes_pkg::KIND_PUSH, pes_pkg::Q_CRIT, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF,
             '0, '0);
        send(pes_pkg::KIND_PUSH, pes_pkg::Q_CRIT, 32'h0, 16'h0, 32'd100, '0, '0);
        send(pes_pkg::KIND_NEXT, 3'd7, '0, '0, '0, 32'd10, '0);
        send(pes_pkg::KIND_NEXT, pes_pkg::Q_SYS, '0, '0, '0, 32'd100, '0);
        send(pes_pkg::KIND_NEXT, pes_pkg::Q_SYS, '0, '0, '0, 32'hFFFF_FFFF, '0);
        for (int i = 0; i < 8; i++) begin
            send(pes_pkg::KIND_PUSH, pes_pkg::Q_SYS, $urandom, 16'($urandom), '0, '0, '0);
        end
        send(pes_pkg::KIND_PUSH, pes_pkg::Q_HIGH, 32'h1234_5678, 16'hABCD, '0, '0, '0);
        send(pes_pkg::KIND_NEXT, pes_pkg::Q_LOW, '0, '0, '0, '0, '0);
        send(pes_pkg::KIND_CHARGE, pes_pkg::Q_HIGH, '0, '0, '0, '0, 15'h7FFF);
        send(pes_pkg::KIND_PUSH, pes_pkg::Q_LOW, 32'h1, 16'h1, '0, '0, '0);
        send(pes_pkg::KIND_REFILL, pes_pkg::Q_LOW, '0, '0, '0, '0, '0);
        drain();

        // The sender keeps offering while the receiver holds off, so the block stalls.
        hold_off = 1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++) random_request(1000);
        join
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(pes_pkg::CFG_SLICE_HIGH, 16'd1);
                    write_reg(pes_pkg::CFG_SLICE_MID, 16'd1);
                    write_reg(pes_pkg::CFG_SLICE_LOW, 16'd1);
                end
                1: begin
                    write_reg(pes_pkg::CFG_SLICE_HIGH, 16'hFFFF);
                    write_reg(pes_pkg::CFG_SLICE_MID, 16'hFFFF);
                    write_reg(pes_pkg::CFG_SLICE_LOW, 16'hFFFF);
                end
                default: begin
                    write_reg(pes_pkg::CFG_SLICE_HIGH, 16'($urandom_range(1, 65535)));
                    write_reg(pes_pkg::CFG_SLICE_MID, 16'($urandom_range(1, 200)));
                    write_reg(pes_pkg::CFG_SLICE_LOW, 16'($urandom_range(1, 40)));
                end
            endcase
            now_base = $urandom;
            for (int i = 0; i < 300; i++) begin
                random_request(now_base);
                now_base += $urandom_range(0, 8);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
